// ----- rtl/sbd_pkg.sv -----
package sbd_pkg;

	localparam int unsigned IN_W   = 112;
	localparam int unsigned OUT_W  = 80;
	localparam int unsigned CADR_W = 2;

	localparam logic [CADR_W-1:0] CFG_WIN_LO    = 2'd0;
	localparam logic [CADR_W-1:0] CFG_WIN_HI    = 2'd1;
	localparam logic [CADR_W-1:0] CFG_THRESHOLD = 2'd2;

	localparam logic EV_SILENCE_END = 1'b0;
	localparam logic EV_BURST_END   = 1'b1;

	localparam logic signed [15:0] DB_FLOOR   = -16'sd30720;
	localparam logic signed [16:0] PEAK_RESET = -17'sd51200;
	localparam logic signed [26:0] DB_K_Q16   = 27'sd50504453;
	localparam logic signed [25:0] SUM_MAX    = 26'sd33554431;
	localparam logic signed [25:0] SUM_MIN    = -26'sd33554432;

	typedef struct packed {
		logic load;
		logic sq;
		logic add;
		logic norm;
		logic log_step;
		logic scale;
		logic acc;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic zero;
		logic normed;
		logic log_last;
		logic out_busy;
	} sts_t;

endpackage

// ----- rtl/spectral_burst_detector_top.sv -----
// One beat at a time: a beat passes the square, add, normalise, log2, scale,
// accumulate and finish states; zero power skips the shifting and the log2 loop.
// The one-bit normalising shifter and the 16-step log2 loop set how long a beat
// takes. A waiting result stalls the following beat in its finish state.
// Reset (arst_n low, asynchronous): idle, quiet, frame cleared, window 0..511,
// threshold 0.
module spectral_burst_detector_top #(
	parameter int unsigned SPECTRUM_BINS = 512
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// bin_re, bin_im, bin_index, now_ms
	input  logic [sbd_pkg::IN_W-1:0]      s_axis_tdata,
	input  logic                          s_axis_tlast,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// bin_db, bin_in_window, peak_level, peak_bin, burst_active, event_valid,
	// event_kind, event_duration_ms
	output logic [sbd_pkg::OUT_W-1:0]     m_axis_tdata,
	output logic                          m_axis_tlast,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sbd_pkg::CADR_W-1:0]    cfg_addr,
	input  logic [15:0]                   cfg_data
);

	sbd_pkg::cmd_t cmd;
	sbd_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	sbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sbd_dp #(
		.SPECTRUM_BINS (SPECTRUM_BINS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.cfg_we    (cfg_valid),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

// ----- rtl/sbd_ctrl.sv -----
module sbd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  sbd_pkg::sts_t sts,
	output sbd_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE, S_SQ, S_ADD, S_NORM, S_LOG, S_SCALE, S_ACC, S_FIN
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:  if (in_valid) state_q <= S_SQ;
				S_SQ:    state_q <= S_ADD;
				S_ADD:   state_q <= S_NORM;
				S_NORM:  if (sts.zero) state_q <= S_SCALE;
					else if (sts.normed) state_q <= S_LOG;
				S_LOG:   if (sts.log_last) state_q <= S_SCALE;
				S_SCALE: state_q <= S_ACC;
				S_ACC:   state_q <= S_FIN;
				S_FIN:   if (!sts.out_busy) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == S_IDLE) && in_valid;
		cmd.sq       = (state_q == S_SQ);
		cmd.add      = (state_q == S_ADD);
		cmd.norm     = (state_q == S_NORM) && !sts.zero;
		cmd.log_step = (state_q == S_LOG);
		cmd.scale    = (state_q == S_SCALE);
		cmd.acc      = (state_q == S_ACC);
		cmd.fin      = (state_q == S_FIN) && !sts.out_busy;
	end

endmodule

// ----- rtl/sbd_dp.sv -----
module sbd_dp #(
	parameter int unsigned SPECTRUM_BINS = 512
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sbd_pkg::cmd_t                 cmd,
	output sbd_pkg::sts_t                 sts,
	input  logic [sbd_pkg::IN_W-1:0]      in_data,
	input  logic                          in_last,
	input  logic                          cfg_we,
	input  logic [sbd_pkg::CADR_W-1:0]    cfg_addr,
	input  logic [15:0]                   cfg_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [sbd_pkg::OUT_W-1:0]     out_data,
	output logic                          out_last
);

	logic [8:0]         win_lo_q, win_hi_q;
	logic signed [15:0] thr_q;

	logic [31:0] ar_q, ai_q, now_q;
	logic [8:0]  bin_q;
	logic        fend_q;
	logic [63:0] sqr_q, sqi_q, p_q;
	logic        zero_q;
	logic [5:0]  e_q;
	logic [31:0] y_q;
	logic [15:0] frac_q;
	logic [3:0]  cnt_q;
	logic signed [49:0] t_q;
	logic signed [15:0] db_q;
	logic        inwin_q;

	logic               in_burst_q;
	logic [31:0]        burst_begin_q, quiet_begin_q;
	logic signed [25:0] sum_q;
	logic [15:0]        count_q;
	logic signed [16:0] peak_q;
	logic [8:0]         peak_bin_q;

	logic out_valid_q, out_last_q;
	logic [sbd_pkg::OUT_W-1:0] out_data_q;

	logic signed [31:0] re_in, im_in;
	logic [8:0]         bin_in;
	logic               inwin_c;
	logic [63:0]        yy;
	logic [32:0]        s_c;
	logic signed [21:0] l2_c;
	logic signed [49:0] tr_c;
	logic signed [17:0] dbw_c;
	logic signed [15:0] db_c;
	logic signed [26:0] sum_c;
	logic signed [25:0] sum_sat_c;
	logic signed [33:0] thr_prod_c;
	logic               above_c;
	logic               ev_c, kind_c, burst_n_c;
	logic [31:0]        dur_c;
	logic signed [16:0] pk_out_c;
	logic [8:0]         pb_out_c;

	assign re_in  = in_data[31:0];
	assign im_in  = in_data[63:32];
	assign bin_in = in_data[72:64];

	assign inwin_c = (bin_in >= win_lo_q) && (bin_in <= win_hi_q) &&
		(32'(bin_in) < SPECTRUM_BINS);

	assign yy  = 64'(y_q) * 64'(y_q);
	assign s_c = yy[63:31];

	assign l2_c = {~e_q[5], e_q[4:0], frac_q};

	assign tr_c  = t_q + 50'sd2147483648;
	assign dbw_c = tr_c[49:32];
	always_comb begin
		if (zero_q) db_c = sbd_pkg::DB_FLOOR;
		else if (dbw_c > 18'sd32767) db_c = 16'sd32767;
		else if (dbw_c < -18'sd32768) db_c = -16'sd32768;
		else db_c = dbw_c[15:0];
	end

	assign sum_c = 27'(sum_q) + 27'(db_c);
	always_comb begin
		if (sum_c > 27'(sbd_pkg::SUM_MAX)) sum_sat_c = sbd_pkg::SUM_MAX;
		else if (sum_c < 27'(sbd_pkg::SUM_MIN)) sum_sat_c = sbd_pkg::SUM_MIN;
		else sum_sat_c = sum_c[25:0];
	end

	assign thr_prod_c = 34'(thr_q) * 34'($signed({1'b0, count_q}));
	assign above_c    = 34'(sum_q) > thr_prod_c;

	always_comb begin
		ev_c      = 1'b0;
		kind_c    = sbd_pkg::EV_SILENCE_END;
		dur_c     = '0;
		burst_n_c = in_burst_q;
		pk_out_c  = '0;
		pb_out_c  = '0;
		if (fend_q) begin
			pk_out_c = peak_q;
			pb_out_c = peak_bin_q;
			if (!in_burst_q && above_c) begin
				ev_c      = 1'b1;
				dur_c     = now_q - quiet_begin_q;
				burst_n_c = 1'b1;
			end else if (in_burst_q && !above_c) begin
				ev_c      = 1'b1;
				kind_c    = sbd_pkg::EV_BURST_END;
				dur_c     = now_q - burst_begin_q;
				burst_n_c = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ar_q    <= re_in[31] ? 32'(-re_in) : 32'(re_in);
			ai_q    <= im_in[31] ? 32'(-im_in) : 32'(im_in);
			bin_q   <= bin_in;
			now_q   <= in_data[104:73];
			fend_q  <= in_last;
			inwin_q <= inwin_c;
		end
		if (cmd.sq) begin
			sqr_q <= 64'(ar_q) * 64'(ar_q);
			sqi_q <= 64'(ai_q) * 64'(ai_q);
		end
		if (cmd.add) begin
			p_q    <= sqr_q + sqi_q;
			zero_q <= (sqr_q == '0) && (sqi_q == '0);
			e_q    <= 6'd63;
		end
		if (cmd.norm) begin
			if (p_q[63]) begin
				y_q    <= p_q[63:32];
				cnt_q  <= 4'd15;
				frac_q <= '0;
			end else begin
				p_q <= {p_q[62:0], 1'b0};
				e_q <= e_q - 6'd1;
			end
		end
		if (cmd.log_step) begin
			frac_q[cnt_q] <= s_c[32];
			y_q           <= s_c[32] ? s_c[32:1] : s_c[31:0];
			cnt_q         <= cnt_q - 4'd1;
		end
		if (cmd.scale) t_q <= 50'(l2_c) * 50'(sbd_pkg::DB_K_Q16);
		if (cmd.acc) db_q <= db_c;
		if (cmd.fin) begin
			out_data_q <= {2'b00, dur_c, kind_c, ev_c, burst_n_c, pb_out_c,
				pk_out_c, inwin_q, db_q};
			out_last_q <= fend_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_lo_q      <= '0;
			win_hi_q      <= 9'd511;
			thr_q         <= '0;
			in_burst_q    <= 1'b0;
			burst_begin_q <= '0;
			quiet_begin_q <= '0;
			sum_q         <= '0;
			count_q       <= '0;
			peak_q        <= sbd_pkg::PEAK_RESET;
			peak_bin_q    <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					sbd_pkg::CFG_WIN_LO:    win_lo_q <= cfg_data[8:0];
					sbd_pkg::CFG_WIN_HI:    win_hi_q <= cfg_data[8:0];
					sbd_pkg::CFG_THRESHOLD: thr_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.acc && inwin_q) begin
				sum_q <= sum_sat_c;
				if (count_q != 16'hFFFF) count_q <= count_q + 16'd1;
				if (17'(db_c) > peak_q) begin
					peak_q     <= 17'(db_c);
					peak_bin_q <= bin_q;
				end
			end
			if (cmd.fin && fend_q) begin
				in_burst_q <= burst_n_c;
				if (ev_c && (kind_c == sbd_pkg::EV_SILENCE_END)) burst_begin_q <= now_q;
				if (ev_c && (kind_c == sbd_pkg::EV_BURST_END)) quiet_begin_q <= now_q;
				sum_q      <= '0;
				count_q    <= '0;
				peak_q     <= sbd_pkg::PEAK_RESET;
				peak_bin_q <= '0;
			end
			if (cmd.fin) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign sts.zero     = zero_q;
	assign sts.normed   = p_q[63];
	assign sts.log_last = (cnt_q == 4'd0);
	assign sts.out_busy = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;

endmodule

// ----- rtl/sbd_checker.sv -----
module sbd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [sbd_pkg::OUT_W-1:0]     m_axis_tdata,
	input logic                          m_axis_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result beat dropped while stalled");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while a beat is in progress");

	a_event_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !m_axis_tdata[44] && !m_axis_tdata[45])
		else $error("event reported off frame end");

	a_no_event_dur: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[44] |-> m_axis_tdata[77:46] == 32'd0)
		else $error("duration without event");

	a_peak_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[42:17] == 26'd0)
		else $error("peak fields set off frame end");

endmodule

bind spectral_burst_detector_top sbd_checker u_sbd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
